// File: rtl/core/bgd_pkg.sv
// Shared types and constants for the button gesture detector.
// No dependencies; used by button_gesture_detector.
`default_nettype none

package bgd_pkg;

   // Time arithmetic width; time stamps wrap modulo 2**TimeWidth (16..64).
   localparam int TimeWidth = 32;

   localparam int NowWidth      = 32;
   localparam int ReqDataWidth  = 40;   // pin_level + now_ms, padded to bytes
   localparam int RspDataWidth  = 24;   // 17 payload bits, padded to bytes
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;

   typedef logic [TimeWidth-1:0] time_type;
   typedef logic signed [7:0]    click_type;

   localparam click_type ClickMax  = 8'sd127;
   localparam click_type ClickHold = -8'sd1;

   typedef enum logic [3:0] {
      ST_START         = 4'd0,
      ST_AWAIT_PRESS   = 4'd1,
      ST_DEB_PRESS     = 4'd2,
      ST_AWAIT_RELEASE = 4'd3,
      ST_DEB_RELEASE   = 4'd4,
      ST_AWAIT_MULTI   = 4'd5,
      ST_LONG_PRESS    = 4'd6,
      ST_DEB_LONG_REL  = 4'd7,
      ST_VLONG_PRESS   = 4'd8,
      ST_DEB_VLONG_REL = 4'd9
   } state_type;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_CLICK     = 3'd1,
      EV_MULTI     = 3'd2,
      EV_HOLD_LONG = 3'd3,
      EV_HOLD_VLONG = 3'd4,
      EV_REL_LONG  = 3'd5,
      EV_REL_VLONG = 3'd6
   } event_type;

   typedef enum logic [1:0] {
      MSG_NONE          = 2'd0,
      MSG_SLOW_POLL     = 2'd1,
      MSG_BOUNCE_PRESS  = 2'd2,
      MSG_BOUNCE_RELEASE = 2'd3
   } msg_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_ACTIVE_LEVEL   = 3'd0,
      CSR_MULTI_ENABLE   = 3'd1,
      CSR_DEB_PRESS      = 3'd2,
      CSR_DEB_RELEASE    = 3'd3,
      CSR_LONG_PRESS     = 3'd4,
      CSR_VLONG_PRESS    = 3'd5,
      CSR_MULTI_WINDOW   = 3'd6,
      CSR_SLOW_POLL      = 3'd7
   } csr_index_type;

endpackage

`default_nettype wire

// File: rtl/core/button_gesture_detector.sv
// Button gesture detector top level: debounce, click counting, long-press detection.
// Depends on bgd_pkg (types, state and event codes, widths).
`default_nettype none

//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  req     | in  | req_tvalid/tready    | tdata: pin_level[0], now_ms[32:1]
//  rsp     | out | rsp_tvalid/tready    | tdata: event[2:0] msg[4:3] click[12:5]
//          |     |                      |        state[16:13]
//  csr     | in  | csr_valid/csr_ready  | csr_index (0..7), csr_data (low bits used)
//
//  One beat in, one beat out. A poll beat sits in the input register, the
//  state step is compare/subtract logic, and the result lands in the output
//  register: one beat per cycle while rsp_tready does not stall the output.
//  Input register and output register together hold two beats, so a new
//  poll is still taken while a finished result waits on rsp_tready.
//  Synchronous reset restores state to start and non-data registers to defaults.
//  csr_ready is always high; writes take effect on the next cycle.

module button_gesture_detector (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire [bgd_pkg::ReqDataWidth-1:0]     req_tdata,   // pin_level, now_ms
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [bgd_pkg::RspDataWidth-1:0]    rsp_tdata,   // event, msg, click, state
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire [bgd_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire [bgd_pkg::CsrDataWidth-1:0]     csr_data
);

   // ---------------- configuration registers ----------------
   logic        active_level_ff;
   logic        multi_enable_ff;
   logic [7:0]  deb_press_ff;
   logic [7:0]  deb_release_ff;
   logic [15:0] long_press_ff;
   logic [15:0] vlong_press_ff;
   logic [15:0] multi_window_ff;
   logic [15:0] slow_poll_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff <= 1'b0;
         multi_enable_ff <= 1'b1;
         deb_press_ff    <= 8'd20;
         deb_release_ff  <= 8'd50;
         long_press_ff   <= 16'd1000;
         vlong_press_ff  <= 16'd3000;
         multi_window_ff <= 16'd300;
         slow_poll_ff    <= 16'd20;
      end else if (csr_valid && csr_ready) begin
         unique case (bgd_pkg::csr_index_type'(csr_index))
            bgd_pkg::CSR_ACTIVE_LEVEL: active_level_ff <= csr_data[0];
            bgd_pkg::CSR_MULTI_ENABLE: multi_enable_ff <= csr_data[0];
            bgd_pkg::CSR_DEB_PRESS:    deb_press_ff    <= csr_data[7:0];
            bgd_pkg::CSR_DEB_RELEASE:  deb_release_ff  <= csr_data[7:0];
            bgd_pkg::CSR_LONG_PRESS:   long_press_ff   <= csr_data;
            bgd_pkg::CSR_VLONG_PRESS:  vlong_press_ff  <= csr_data;
            bgd_pkg::CSR_MULTI_WINDOW: multi_window_ff <= csr_data;
            bgd_pkg::CSR_SLOW_POLL:    slow_poll_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- input register ----------------
   logic                          in_valid_ff;
   logic                          in_pin_ff;
   logic [bgd_pkg::NowWidth-1:0]  in_now_ff;
   logic                          advance;

   // output slot frees up when empty or being drained this cycle
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_pin_ff <= req_tdata[0];
         in_now_ff <= req_tdata[bgd_pkg::NowWidth:1];
      end
   end

   // ---------------- detector state ----------------
   bgd_pkg::state_type  state_ff,   state_in;
   bgd_pkg::click_type  click_ff,   click_in;
   bgd_pkg::event_type  event_ff,   event_in;
   bgd_pkg::time_type   press_ff,   press_in;
   bgd_pkg::time_type   release_ff, release_in;
   bgd_pkg::time_type   last_ff;
   bgd_pkg::msg_type    msg;

   logic               step;
   logic               pressed;
   bgd_pkg::time_type  now_t;
   bgd_pkg::time_type  gap;
   bgd_pkg::time_type  since_press;
   bgd_pkg::time_type  since_release;
   logic               slow;
   logic               press_done;     // press held past debounce
   logic               release_done;   // release held past debounce
   logic               long_reached;
   logic               hold_vlong;
   logic               window_open;

   assign step    = in_valid_ff && advance;
   assign pressed = (in_pin_ff == active_level_ff);
   assign now_t   = bgd_pkg::time_type'(in_now_ff);

   // all differences wrap modulo the time width
   assign gap           = now_t - last_ff;
   assign since_press   = now_t - press_ff;
   assign since_release = now_t - release_ff;

   assign slow         = (gap >= bgd_pkg::time_type'(slow_poll_ff));
   assign press_done   = (since_press > bgd_pkg::time_type'(deb_press_ff));
   assign release_done = (since_release > bgd_pkg::time_type'(deb_release_ff));
   assign long_reached = (since_press > bgd_pkg::time_type'(long_press_ff));
   assign hold_vlong   = (since_press > bgd_pkg::time_type'(vlong_press_ff));
   assign window_open  = (since_release < bgd_pkg::time_type'(multi_window_ff))
                         && multi_enable_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bgd_pkg::ST_START: state_in = bgd_pkg::ST_AWAIT_PRESS;
         bgd_pkg::ST_AWAIT_PRESS: begin
            if (pressed) state_in = bgd_pkg::ST_DEB_PRESS;
         end
         bgd_pkg::ST_DEB_PRESS: begin
            if (!pressed) state_in = bgd_pkg::ST_AWAIT_PRESS;
            else if (press_done) state_in = bgd_pkg::ST_AWAIT_RELEASE;
         end
         bgd_pkg::ST_AWAIT_RELEASE: begin
            if (!pressed) state_in = bgd_pkg::ST_DEB_RELEASE;
            else if (long_reached) state_in = bgd_pkg::ST_LONG_PRESS;
         end
         bgd_pkg::ST_DEB_RELEASE: begin
            if (pressed) state_in = bgd_pkg::ST_AWAIT_RELEASE;
            else if (release_done) state_in = bgd_pkg::ST_AWAIT_MULTI;
         end
         bgd_pkg::ST_AWAIT_MULTI: begin
            if (!window_open) state_in = bgd_pkg::ST_AWAIT_PRESS;
            else if (pressed) state_in = bgd_pkg::ST_DEB_PRESS;
         end
         bgd_pkg::ST_LONG_PRESS: begin
            if (!pressed) state_in = bgd_pkg::ST_DEB_LONG_REL;
            else if (hold_vlong) state_in = bgd_pkg::ST_VLONG_PRESS;
         end
         bgd_pkg::ST_DEB_LONG_REL: begin
            if (pressed) state_in = bgd_pkg::ST_LONG_PRESS;
            else if (release_done) state_in = bgd_pkg::ST_AWAIT_PRESS;
         end
         bgd_pkg::ST_VLONG_PRESS: begin
            if (!pressed) state_in = bgd_pkg::ST_DEB_VLONG_REL;
         end
         bgd_pkg::ST_DEB_VLONG_REL: begin
            if (pressed) state_in = bgd_pkg::ST_VLONG_PRESS;
            else if (release_done) state_in = bgd_pkg::ST_AWAIT_PRESS;
         end
         default: state_in = bgd_pkg::ST_START;   // stray codes restart
      endcase
   end

   // event, click count, message and time stamps
   always_comb begin
      msg        = slow ? bgd_pkg::MSG_SLOW_POLL : bgd_pkg::MSG_NONE;
      event_in   = event_ff;
      click_in   = click_ff;
      press_in   = press_ff;
      release_in = release_ff;
      unique case (state_ff)
         bgd_pkg::ST_START: begin
            click_in = '0;
            event_in = bgd_pkg::EV_NONE;
            msg      = bgd_pkg::MSG_NONE;
         end
         bgd_pkg::ST_AWAIT_PRESS: begin
            click_in = '0;
            event_in = bgd_pkg::EV_NONE;
            msg      = bgd_pkg::MSG_NONE;
            if (pressed) press_in = now_t;
         end
         bgd_pkg::ST_DEB_PRESS: begin
            if (!pressed) msg = bgd_pkg::MSG_BOUNCE_PRESS;
            else if (press_done) msg = bgd_pkg::MSG_NONE;
         end
         bgd_pkg::ST_AWAIT_RELEASE: begin
            msg = bgd_pkg::MSG_NONE;
            if (!pressed) begin
               release_in = now_t;
            end else if (long_reached) begin
               event_in = bgd_pkg::EV_HOLD_LONG;
               click_in = bgd_pkg::ClickHold;
            end
         end
         bgd_pkg::ST_DEB_RELEASE: begin
            if (pressed) begin
               msg = bgd_pkg::MSG_BOUNCE_RELEASE;
            end else if (release_done && (click_ff < bgd_pkg::ClickMax)) begin
               click_in = click_ff + 8'sd1;
            end
         end
         bgd_pkg::ST_AWAIT_MULTI: begin
            if (window_open) begin
               if (pressed) press_in = now_t;
            end else if (click_ff == 8'sd1) begin
               event_in = bgd_pkg::EV_CLICK;
            end else if (click_ff > 8'sd1) begin
               event_in = bgd_pkg::EV_MULTI;
            end else begin
               event_in = bgd_pkg::EV_NONE;
            end
         end
         bgd_pkg::ST_LONG_PRESS: begin
            if (!pressed) begin
               release_in = now_t;
            end else if (hold_vlong) begin
               event_in = bgd_pkg::EV_HOLD_VLONG;
            end else begin
               event_in = bgd_pkg::EV_NONE;
               msg      = bgd_pkg::MSG_NONE;
               click_in = '0;
            end
         end
         bgd_pkg::ST_DEB_LONG_REL: begin
            if (pressed) msg = bgd_pkg::MSG_BOUNCE_RELEASE;
            else if (release_done) event_in = bgd_pkg::EV_REL_LONG;
         end
         bgd_pkg::ST_VLONG_PRESS: begin
            if (!pressed) begin
               release_in = now_t;
            end else begin
               event_in = bgd_pkg::EV_NONE;
               click_in = '0;
            end
         end
         bgd_pkg::ST_DEB_VLONG_REL: begin
            if (pressed) msg = bgd_pkg::MSG_BOUNCE_RELEASE;
            else if (release_done) event_in = bgd_pkg::EV_REL_VLONG;
         end
         default: begin
            event_in = bgd_pkg::EV_NONE;
            click_in = '0;
            msg      = bgd_pkg::MSG_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bgd_pkg::ST_START;
         click_ff   <= '0;
         event_ff   <= bgd_pkg::EV_NONE;
         press_ff   <= '0;
         release_ff <= '0;
         last_ff    <= '0;
      end else if (step) begin
         state_ff   <= state_in;
         click_ff   <= click_in;
         event_ff   <= event_in;
         press_ff   <= press_in;
         release_ff <= release_in;
         last_ff    <= now_t;
      end
   end

   // ---------------- output register ----------------
   logic                              rsp_valid_ff;
   logic [bgd_pkg::RspDataWidth-1:0]  rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= {7'd0, state_in, click_in, msg, event_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- assertions ----------------
   // the start state is only ever left, never re-entered from a legal state
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      step |=> state_ff != bgd_pkg::ST_START)
      else $error("detector returned to start state");

   // click count stays within -1..127
   a_click_range: assert property (@(posedge clock) disable iff (reset)
      click_ff >= bgd_pkg::ClickHold)
      else $error("click count below -1");

   // a pending result always reports the current state
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[16:13] == state_ff)
      else $error("result state field out of step with detector");

   // a poll held in the input register is not lost while the output stalls
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff && $stable(in_now_ff))
      else $error("stalled poll dropped");

endmodule

`default_nettype wire

// File: test/button_gesture_detector_test.sv
`timescale 1ns / 100ps
// Self-checking bench for button_gesture_detector: sends poll beats on req, predicts each
// rsp beat with an in-bench gesture machine and compares it field by field.
// Depends on bgd_pkg and the button_gesture_detector RTL.

module button_gesture_detector_test;

   // rsp_tdata layout, lowest bits first: gesture, status, clicks, fsm
   typedef struct packed {
      bgd_pkg::state_type fsm;
      bgd_pkg::click_type clicks;
      bgd_pkg::msg_type   status;
      bgd_pkg::event_type gesture;
   } outcome_type;

   localparam int HoldOffCycles = 60;   // long receiver stall, fills the two-beat pipe

   logic clock = 1'b0;
   logic reset;

   logic                              req_tvalid;
   logic                              req_tready;
   logic [bgd_pkg::ReqDataWidth-1:0]  req_tdata;    // pin_level, now_ms
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [bgd_pkg::RspDataWidth-1:0]  rsp_tdata;    // event, msg, click, state
   logic                              csr_valid;
   logic                              csr_ready;
   logic [bgd_pkg::CsrIndexWidth-1:0] csr_index;
   logic [bgd_pkg::CsrDataWidth-1:0]  csr_data;

   button_gesture_detector u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror of the register file, reset values
   logic        cfg_active      = 1'b0;
   logic        cfg_multi       = 1'b1;
   logic [7:0]  cfg_deb_press   = 8'd20;
   logic [7:0]  cfg_deb_release = 8'd50;
   logic [15:0] cfg_long        = 16'd1000;
   logic [15:0] cfg_vlong       = 16'd3000;
   logic [15:0] cfg_window      = 16'd300;
   logic [15:0] cfg_slow        = 16'd20;

   // Mirror of the gesture machine
   bgd_pkg::state_type mdl_state     = bgd_pkg::ST_START;
   bgd_pkg::click_type mdl_clicks    = '0;
   bgd_pkg::time_type  mdl_press_t   = '0;
   bgd_pkg::time_type  mdl_release_t = '0;
   bgd_pkg::time_type  mdl_last_poll = '0;
   bgd_pkg::event_type mdl_event     = bgd_pkg::EV_NONE;

   outcome_type pending_outcomes[$];   // predicted rsp beats, oldest first

   bgd_pkg::time_type now_t = '0;      // time stamp of the latest poll sent
   bit          steady = 1'b0;         // no idle cycles on either side
   bit          hold_off_req = 1'b0;   // receiver stalls for HoldOffCycles
   int unsigned polls_sent = 0;
   int unsigned beats_checked = 0;
   int unsigned mismatches = 0;
   int unsigned settings_loaded = 0;
   int unsigned event_beats[8];

   function automatic bgd_pkg::time_type since(bgd_pkg::time_type later,
                                               bgd_pkg::time_type earlier);
      return later - earlier;   // wraps modulo 2**TimeWidth
   endfunction

   // One poll through the gesture machine; returns the rsp beat it produces.
   function automatic outcome_type advance_gesture(logic pin,
                                                   logic [bgd_pkg::NowWidth-1:0] stamp);
      logic              down;
      bgd_pkg::time_type now;
      bgd_pkg::msg_type  msg;
      outcome_type       res;
      down = (pin == cfg_active);
      now  = bgd_pkg::time_type'(stamp);
      // slow-poll flag first, the state logic may overwrite it
      msg  = (since(now, mdl_last_poll) >= bgd_pkg::time_type'(cfg_slow)) ?
             bgd_pkg::MSG_SLOW_POLL : bgd_pkg::MSG_NONE;
      mdl_last_poll = now;
      case (mdl_state)
         bgd_pkg::ST_START: begin
            mdl_clicks = '0;
            mdl_event  = bgd_pkg::EV_NONE;
            msg        = bgd_pkg::MSG_NONE;
            mdl_state  = bgd_pkg::ST_AWAIT_PRESS;
         end
         bgd_pkg::ST_AWAIT_PRESS: begin
            mdl_clicks = '0;
            mdl_event  = bgd_pkg::EV_NONE;
            msg        = bgd_pkg::MSG_NONE;
            if (down) begin
               mdl_press_t = now;
               mdl_state   = bgd_pkg::ST_DEB_PRESS;
            end
         end
         bgd_pkg::ST_DEB_PRESS: begin
            if (down) begin
               if (since(now, mdl_press_t) > bgd_pkg::time_type'(cfg_deb_press)) begin
                  mdl_state = bgd_pkg::ST_AWAIT_RELEASE;
                  msg       = bgd_pkg::MSG_NONE;
               end
            end else begin
               mdl_state = bgd_pkg::ST_AWAIT_PRESS;
               msg       = bgd_pkg::MSG_BOUNCE_PRESS;
            end
         end
         bgd_pkg::ST_AWAIT_RELEASE: begin
            msg = bgd_pkg::MSG_NONE;
            if (!down) begin
               mdl_release_t = now;
               mdl_state     = bgd_pkg::ST_DEB_RELEASE;
            end else if (since(now, mdl_press_t) > bgd_pkg::time_type'(cfg_long)) begin
               mdl_event  = bgd_pkg::EV_HOLD_LONG;
               mdl_state  = bgd_pkg::ST_LONG_PRESS;
               mdl_clicks = bgd_pkg::ClickHold;
            end
         end
         bgd_pkg::ST_DEB_RELEASE: begin
            if (!down) begin
               if (since(now, mdl_release_t) > bgd_pkg::time_type'(cfg_deb_release)) begin
                  if (mdl_clicks < bgd_pkg::ClickMax) mdl_clicks = mdl_clicks + 8'sd1;
                  mdl_state = bgd_pkg::ST_AWAIT_MULTI;
               end
            end else begin
               mdl_state = bgd_pkg::ST_AWAIT_RELEASE;
               msg       = bgd_pkg::MSG_BOUNCE_RELEASE;
            end
         end
         bgd_pkg::ST_AWAIT_MULTI: begin
            if (since(now, mdl_release_t) < bgd_pkg::time_type'(cfg_window) && cfg_multi)
            begin
               if (down) begin
                  mdl_press_t = now;
                  mdl_state   = bgd_pkg::ST_DEB_PRESS;
               end
            end else begin
               mdl_state = bgd_pkg::ST_AWAIT_PRESS;
               if (mdl_clicks == 8'sd1)     mdl_event = bgd_pkg::EV_CLICK;
               else if (mdl_clicks > 8'sd1) mdl_event = bgd_pkg::EV_MULTI;
               else                         mdl_event = bgd_pkg::EV_NONE;
            end
         end
         bgd_pkg::ST_LONG_PRESS: begin
            if (!down) begin
               mdl_release_t = now;
               mdl_state     = bgd_pkg::ST_DEB_LONG_REL;
            end else if (since(now, mdl_press_t) > bgd_pkg::time_type'(cfg_vlong)) begin
               mdl_state = bgd_pkg::ST_VLONG_PRESS;
               mdl_event = bgd_pkg::EV_HOLD_VLONG;
            end else begin
               mdl_event  = bgd_pkg::EV_NONE;
               msg        = bgd_pkg::MSG_NONE;
               mdl_clicks = '0;
            end
         end
         bgd_pkg::ST_DEB_LONG_REL: begin
            if (!down) begin
               if (since(now, mdl_release_t) > bgd_pkg::time_type'(cfg_deb_release)) begin
                  mdl_event = bgd_pkg::EV_REL_LONG;
                  mdl_state = bgd_pkg::ST_AWAIT_PRESS;
               end
            end else begin
               mdl_state = bgd_pkg::ST_LONG_PRESS;
               msg       = bgd_pkg::MSG_BOUNCE_RELEASE;
            end
         end
         bgd_pkg::ST_VLONG_PRESS: begin
            if (!down) begin
               mdl_release_t = now;
               mdl_state     = bgd_pkg::ST_DEB_VLONG_REL;
            end else begin
               mdl_event  = bgd_pkg::EV_NONE;
               mdl_clicks = '0;
            end
         end
         bgd_pkg::ST_DEB_VLONG_REL: begin
            if (!down) begin
               if (since(now, mdl_release_t) > bgd_pkg::time_type'(cfg_deb_release)) begin
                  mdl_event = bgd_pkg::EV_REL_VLONG;
                  mdl_state = bgd_pkg::ST_AWAIT_PRESS;
               end
            end else begin
               mdl_state = bgd_pkg::ST_VLONG_PRESS;
               msg       = bgd_pkg::MSG_BOUNCE_RELEASE;
            end
         end
         default: begin
            mdl_state  = bgd_pkg::ST_START;
            mdl_event  = bgd_pkg::EV_NONE;
            mdl_clicks = '0;
            msg        = bgd_pkg::MSG_NONE;
         end
      endcase
      res.gesture = mdl_event;
      res.status  = msg;
      res.clicks  = mdl_clicks;
      res.fsm     = mdl_state;
      return res;
   endfunction

   // One poll beat on req. tvalid is only lowered for idle cycles, so back-to-back
   // beats never see a low and a high assignment in the same time step.
   task automatic send_poll(input logic pin, input logic [bgd_pkg::NowWidth-1:0] stamp);
      while (!steady && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(bgd_pkg::ReqDataWidth - bgd_pkg::NowWidth - 1){1'b0}}, stamp, pin};
      do @(posedge clock); while (!req_tready);
      pending_outcomes.push_back(advance_gesture(pin, stamp));
      polls_sent++;
   endtask

   // Poll in button terms: down means the pressed level under the current setting.
   task automatic poll_button(input logic down, input bgd_pkg::time_type stamp);
      now_t = stamp;
      send_poll(down ? cfg_active : ~cfg_active, stamp);
   endtask

   // Keep the button at one level for at least dur ms, polling at random gaps.
   task automatic hold_level(input logic down, input int unsigned dur);
      bgd_pkg::time_type t0;
      t0 = now_t;
      poll_button(down, now_t);
      while (since(now_t, t0) < dur) begin
         poll_button(down, now_t + $urandom_range(dur / 4 + 1));
      end
   endtask

   task automatic write_reg(input bgd_pkg::csr_index_type idx,
                            input logic [bgd_pkg::CsrDataWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         bgd_pkg::CSR_ACTIVE_LEVEL: cfg_active      = value[0];
         bgd_pkg::CSR_MULTI_ENABLE: cfg_multi       = value[0];
         bgd_pkg::CSR_DEB_PRESS:    cfg_deb_press   = value[7:0];
         bgd_pkg::CSR_DEB_RELEASE:  cfg_deb_release = value[7:0];
         bgd_pkg::CSR_LONG_PRESS:   cfg_long        = value;
         bgd_pkg::CSR_VLONG_PRESS:  cfg_vlong       = value;
         bgd_pkg::CSR_MULTI_WINDOW: cfg_window      = value;
         bgd_pkg::CSR_SLOW_POLL:    cfg_slow        = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_settings(input logic active, input logic multi,
                                input logic [7:0] deb_press, input logic [7:0] deb_release,
                                input logic [15:0] long_ms, input logic [15:0] vlong_ms,
                                input logic [15:0] window_ms, input logic [15:0] slow_ms);
      write_reg(bgd_pkg::CSR_ACTIVE_LEVEL, {15'd0, active});
      write_reg(bgd_pkg::CSR_MULTI_ENABLE, {15'd0, multi});
      write_reg(bgd_pkg::CSR_DEB_PRESS, {8'd0, deb_press});
      write_reg(bgd_pkg::CSR_DEB_RELEASE, {8'd0, deb_release});
      write_reg(bgd_pkg::CSR_LONG_PRESS, long_ms);
      write_reg(bgd_pkg::CSR_VLONG_PRESS, vlong_ms);
      write_reg(bgd_pkg::CSR_MULTI_WINDOW, window_ms);
      write_reg(bgd_pkg::CSR_SLOW_POLL, slow_ms);
      settings_loaded++;
   endtask

   // Sender goes quiet until every predicted beat is back, then lets the
   // pipe settle so register writes hit an idle block.
   task automatic wait_for_results();
      int unsigned guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   // A run of one to four clicks, sometimes with a bouncy press or release.
   task automatic run_clicks();
      int unsigned n;
      n = $urandom_range(1, 4);
      repeat (n) begin
         if ($urandom_range(3) == 0) begin
            hold_level(1'b1, $urandom_range(cfg_deb_press));
            hold_level(1'b0, $urandom_range(5));
         end
         hold_level(1'b1, cfg_deb_press + 1 + $urandom_range(30));
         if ($urandom_range(3) == 0) begin
            hold_level(1'b0, $urandom_range(cfg_deb_release));
            hold_level(1'b1, $urandom_range(5));
         end
         hold_level(1'b0, cfg_deb_release + 1 + $urandom_range(30));
      end
      // let the multi-click window run out
      hold_level(1'b0, cfg_window + $urandom_range(1, 50));
   endtask

   // Mostly well-formed gestures sized to the current settings, some noise.
   task automatic random_gestures(input int unsigned count);
      int unsigned stop_at;
      int unsigned pick;
      int unsigned span;
      stop_at = polls_sent + count;
      while (polls_sent < stop_at) begin
         pick = $urandom_range(19);
         if (pick < 10) begin
            run_clicks();
         end else if (pick < 15) begin
            // hold past long or very long, then release, sometimes with a bounce
            span = ($urandom_range(1) ? cfg_long : cfg_vlong) + 1 + $urandom_range(200);
            hold_level(1'b1, span);
            if ($urandom_range(2) == 0) begin
               hold_level(1'b0, $urandom_range(cfg_deb_release));
               hold_level(1'b1, $urandom_range(5));
            end
            hold_level(1'b0, cfg_deb_release + 1 + $urandom_range(30));
         end else if (pick < 18) begin
            // noise: random level, short gaps mostly, sometimes any time stamp
            repeat ($urandom_range(3, 8)) begin
               span = $urandom_range(9);
               if (span < 7)      now_t = now_t + $urandom_range(30);
               else if (span < 9) now_t = now_t + $urandom_range(2000);
               else               now_t = $urandom();
               send_poll(1'($urandom_range(1)), now_t);
            end
         end else begin
            hold_level(1'b0, $urandom_range(cfg_window + 100));
         end
      end
   endtask

   // Reset settings: pressed means the pin is low, 20 ms / 50 ms debounce.
   task automatic test_directed_gestures();
      poll_button(1'b0, 32'd0);      // start -> await press, time stamp floor
      poll_button(1'b1, 32'd5);      // press seen
      poll_button(1'b0, 32'd8);      // bounce on press
      poll_button(1'b1, 32'd10);
      poll_button(1'b1, 32'd40);     // press debounced
      poll_button(1'b0, 32'd50);
      poll_button(1'b1, 32'd55);     // bounce on release
      poll_button(1'b0, 32'd60);
      poll_button(1'b0, 32'd120);    // first click, gap is a slow poll
      poll_button(1'b1, 32'd130);    // second press inside the window
      poll_button(1'b1, 32'd160);
      poll_button(1'b0, 32'd170);
      poll_button(1'b0, 32'd230);
      poll_button(1'b0, 32'd600);    // window over -> multi click
      poll_button(1'b1, 32'd610);
      poll_button(1'b1, 32'd640);
      poll_button(1'b1, 32'd1700);   // hold long, clicks go to -1
      poll_button(1'b1, 32'd1710);
      poll_button(1'b1, 32'd3700);   // hold very long
      poll_button(1'b0, 32'd3710);
      poll_button(1'b1, 32'd3715);   // bounce on very long release
      poll_button(1'b0, 32'd3720);
      poll_button(1'b0, 32'd3800);   // released very long
      poll_button(1'b1, 32'd3810);
      poll_button(1'b1, 32'd3840);
      poll_button(1'b1, 32'd4900);   // hold long
      poll_button(1'b0, 32'd4910);
      poll_button(1'b1, 32'd4915);   // bounce on long release
      poll_button(1'b0, 32'd4920);
      poll_button(1'b0, 32'd5000);   // released long
   endtask

   // A click whose press and release straddle the 32-bit time wrap.
   task automatic test_time_wrap();
      poll_button(1'b0, 32'hFFFF_FFF0);
      poll_button(1'b1, 32'hFFFF_FFFF);   // all-ones time stamp
      poll_button(1'b1, 32'h0000_0010);   // 17 ms: still debouncing
      poll_button(1'b1, 32'h0000_0020);   // 33 ms: debounced
      poll_button(1'b0, 32'h0000_0030);
      poll_button(1'b0, 32'h0000_0070);
      poll_button(1'b0, 32'h0000_0200);   // window over -> click
   endtask

   // 130 quick clicks in one run; the count has to stop at 127.
   task automatic test_click_saturation();
      wait_for_results();
      load_settings(1'b1, 1'b1, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'($urandom_range(4)));
      repeat (130) begin
         for (int k = 0; k < 4; k++) begin
            poll_button(k < 2, now_t + $urandom_range(1, 3));
         end
      end
      poll_button(1'b0, now_t + 32'd65535 + $urandom_range(10));
   endtask

   // Reset values, floor, ceiling, then random settings.
   task automatic test_config_sweep();
      int unsigned lp;
      wait_for_results();
      load_settings(1'b0, 1'b1, 8'd20, 8'd50, 16'd1000, 16'd3000, 16'd300, 16'd20);
      steady = 1'b1;   // stretch with no idling on either side
      random_gestures(30);
      steady = 1'b0;
      wait_for_results();
      load_settings(1'b0, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      random_gestures(20);
      wait_for_results();
      load_settings(1'b1, 1'b1, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_gestures(20);
      repeat (2) begin
         wait_for_results();
         lp = $urandom_range(3000);
         load_settings(1'($urandom_range(1)), 1'($urandom_range(1)),
                       8'($urandom_range(255)), 8'($urandom_range(255)),
                       16'(lp), 16'(lp + $urandom_range(3000)),
                       16'($urandom_range(800)), 16'($urandom_range(60)));
         random_gestures(20);
      end
   endtask

   // Receiver stalls while the sender keeps offering; then a full drain mid-stream.
   task automatic test_backpressure();
      wait_for_results();
      load_settings(1'b1, 1'b1, 8'd5, 8'd10, 16'd200, 16'd600, 16'd100, 16'd8);
      steady       = 1'b1;
      hold_off_req = 1'b1;
      while (hold_off_req) run_clicks();
      steady = 1'b0;
      random_gestures(20);
      wait_for_results();
      random_gestures(20);
   endtask

   // Receiver: random tready, a steady stretch, and the long hold-off on request.
   initial begin : rsp_ready_driver
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 18);
         end
      end
   end

   // Every rsp beat against the oldest prediction.
   always @(posedge clock) begin : rsp_checker
      outcome_type want;
      outcome_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = outcome_type'(rsp_tdata[$bits(outcome_type)-1:0]);
         event_beats[got.gesture]++;
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            $display("ERROR @%0t: rsp beat with nothing expected, %s%0d %0d %0d %0d",
                     $time, "got ev/msg/clicks/st = ",
                     got.gesture, got.status, got.clicks, got.fsm);
         end else begin
            want = pending_outcomes.pop_front();
            beats_checked++;
            if (got.gesture !== want.gesture || got.status !== want.status ||
                got.clicks !== want.clicks || got.fsm !== want.fsm) begin
               mismatches++;
               $display("ERROR @%0t: expected ev=%0d msg=%0d clicks=%0d st=%0d,",
                        $time, want.gesture, want.status, want.clicks, want.fsm);
               $display("           actual ev=%0d msg=%0d clicks=%0d st=%0d",
                        got.gesture, got.status, got.clicks, got.fsm);
            end
         end
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("ERROR @%0t: timeout, %0d beats outstanding", $time, pending_outcomes.size());
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      reset      <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_gestures();
      test_time_wrap();
      test_click_saturation();
      test_config_sweep();
      test_backpressure();

      wait_for_results();
      repeat (8) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         mismatches += pending_outcomes.size();
         $display("ERROR @%0t: %0d predicted beats never arrived", $time,
                  pending_outcomes.size());
      end
      $display("Covered %0d polls, %0d rsp beats checked, %0d register settings %s",
               polls_sent, beats_checked, settings_loaded, "(wrap, 127-click run, stalls).");
      $display("Beats per gesture: click %0d multi %0d long %0d vlong %0d %s %0d %s %0d",
               event_beats[bgd_pkg::EV_CLICK], event_beats[bgd_pkg::EV_MULTI],
               event_beats[bgd_pkg::EV_HOLD_LONG], event_beats[bgd_pkg::EV_HOLD_VLONG],
               "rel-long", event_beats[bgd_pkg::EV_REL_LONG],
               "rel-vlong", event_beats[bgd_pkg::EV_REL_VLONG]);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
